// File: hdl/crtc_scanline_address_generator_unit_macros.svh
// Assertion macros for the CRTC scanline address generator.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef CRTC_SCANLINE_ADDRESS_GENERATOR_UNIT_MACROS_SVH
`define CRTC_SCANLINE_ADDRESS_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CRTC_SAG_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("crtc_sag: same-cycle check failed");

// next-cycle implication
`define CRTC_SAG_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("crtc_sag: next-cycle check failed");

`endif

// File: hdl/crtc_sag_pkg.sv
// Shared types and constants for the CRTC scanline address generator.
// No dependencies.
`default_nettype none

package crtc_sag_pkg;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // register index in the map (byte address = 4 * index)
   localparam logic [2:0] REG_DISPLAY_MODE  = 3'd0;
   localparam logic [2:0] REG_START_ADDR    = 3'd1;
   localparam logic [2:0] REG_PAN_SKIP      = 3'd2;
   localparam logic [2:0] REG_SPLIT_COMPARE = 3'd3;
   localparam logic [2:0] REG_ROW_OFFSET    = 3'd4;
   localparam logic [2:0] REG_ROWS_PER_CHAR = 3'd5;
   localparam logic [2:0] REG_FRAME_LINES   = 3'd6;
   localparam logic [2:0] REG_OPTIONS       = 3'd7;

   localparam logic [1:0] DISP_TEXT = 2'd0;
   localparam logic [1:0] DISP_VGA  = 2'd1;
   localparam logic [1:0] DISP_EGA  = 2'd2;

   localparam logic ITEM_FRAME_START = 1'b0;
   localparam logic ITEM_LINE_TICK   = 1'b1;

   localparam logic [14:0] TEXT_MASK = 15'h7fff;
   localparam logic [12:0] CGA_MASK  = 13'h1fff;
   localparam logic [5:0]  ROWS_MAX  = 6'h20;
   localparam logic [13:0] CGA_STEP  = 14'd80;

   typedef struct packed {
      logic mode;
      logic screen_blank;
   } req_type;

   typedef struct packed {
      logic [17:0] fetch_address;
      logic [4:0]  char_row;
      logic        blank;
      logic        last_line;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  display_mode;
      logic [15:0] start_addr;
      logic [1:0]  pan_skip;
      logic [9:0]  split_compare;
      logic [9:0]  row_offset;
      logic [5:0]  rows_per_char;
      logic [10:0] frame_lines;
      logic [6:0]  options;
   } cfg_type;

endpackage

`default_nettype wire

// File: hdl/crtc_scanline_address_generator_unit.sv
// CRTC scanline address generator. Accepts one request per clock while
// req_stall is low. A line-tick request inside a drawn frame gives one
// response, through the input register, then the output register; a
// frame-start request, or a tick before the first frame start or after the
// last line of the frame, gives no response. The only input stall is a full
// output register held by rsp_stall while the waiting request would respond.
// The engine state updates as each request moves on, at one per clock unless
// stalled. Configuration sits in crtc_sag_csr behind the APB-style port; the
// user must write it only with no request in flight; the block does not enforce it.
// Depends on crtc_sag_pkg, crtc_sag_csr, crtc_sag_engine and the macros header.
`default_nettype none
`include "crtc_scanline_address_generator_unit_macros.svh"

module crtc_scanline_address_generator_unit import crtc_sag_pkg::*; #(
   parameter int ADDR_BITS = 18
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire req_type                  req_data,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      rsp_type                  rsp_data,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0] csr_prdata,
   output      logic                     csr_pready
);

   cfg_type cfg;
   req_type s1_data_ff;
   logic    s1_valid_ff, s1_valid_in;
   rsp_type out_data_ff;
   logic    out_valid_ff, out_valid_in;
   logic    produces, s1_move, accept, has_result;
   rsp_type result;

   crtc_sag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   crtc_sag_engine #(.ADDR_BITS(ADDR_BITS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (s1_move),
      .item       (s1_data_ff),
      .cfg        (cfg),
      .has_result (has_result),
      .result     (result)
   );

   assign produces  = s1_valid_ff & has_result;
   // requests that give no response never wait on the output side
   assign s1_move   = s1_valid_ff & (~has_result | ~out_valid_ff | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~s1_move;
   assign accept    = req_valid & ~req_stall;

   assign s1_valid_in  = accept | (s1_valid_ff & ~s1_move);
   assign out_valid_in = (s1_move & produces) | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_move & produces) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `CRTC_SAG_ASSERT_NEXT(a_result_loads, s1_move && produces, rsp_valid)
   `CRTC_SAG_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall && s1_valid_ff)
   `CRTC_SAG_ASSERT_NEXT(a_silent_item, s1_move && !produces,
      rsp_valid == $past(rsp_valid && rsp_stall))

endmodule

`default_nettype wire

// File: hdl/crtc_sag_csr.sv
// APB-style configuration register bank for the scanline address generator.
// Depends on crtc_sag_pkg.
`default_nettype none

module crtc_sag_csr import crtc_sag_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output      logic [CSR_DATA_BITS-1:0] csr_prdata,
   output      logic                     csr_pready,
   output      cfg_type                  cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_mode  <= 2'd0;
         cfg_ff.start_addr    <= 16'd0;
         cfg_ff.pan_skip      <= 2'd0;
         cfg_ff.split_compare <= 10'd1023;
         cfg_ff.row_offset    <= 10'd40;
         cfg_ff.rows_per_char <= 6'd16;
         cfg_ff.frame_lines   <= 11'd400;
         cfg_ff.options       <= 7'd0;
      end else if (wr_en) begin
         case (reg_idx)
            REG_DISPLAY_MODE:  cfg_ff.display_mode  <= csr_pwdata[1:0];
            REG_START_ADDR:    cfg_ff.start_addr    <= csr_pwdata[15:0];
            REG_PAN_SKIP:      cfg_ff.pan_skip      <= csr_pwdata[1:0];
            REG_SPLIT_COMPARE: cfg_ff.split_compare <= csr_pwdata[9:0];
            REG_ROW_OFFSET:    cfg_ff.row_offset    <= csr_pwdata[9:0];
            REG_ROWS_PER_CHAR: cfg_ff.rows_per_char <= csr_pwdata[5:0];
            REG_FRAME_LINES:   cfg_ff.frame_lines   <= csr_pwdata[10:0];
            REG_OPTIONS:       cfg_ff.options       <= csr_pwdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DISPLAY_MODE:  csr_prdata = 32'(cfg_ff.display_mode);
         REG_START_ADDR:    csr_prdata = 32'(cfg_ff.start_addr);
         REG_PAN_SKIP:      csr_prdata = 32'(cfg_ff.pan_skip);
         REG_SPLIT_COMPARE: csr_prdata = 32'(cfg_ff.split_compare);
         REG_ROW_OFFSET:    csr_prdata = 32'(cfg_ff.row_offset);
         REG_ROWS_PER_CHAR: csr_prdata = 32'(cfg_ff.rows_per_char);
         REG_FRAME_LINES:   csr_prdata = 32'(cfg_ff.frame_lines);
         REG_OPTIONS:       csr_prdata = 32'(cfg_ff.options);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/crtc_sag_engine.sv
// Scanline address state and its update for one request.
// Depends on crtc_sag_pkg.
`default_nettype none

module crtc_sag_engine import crtc_sag_pkg::*; #(
   parameter int ADDR_BITS = 18
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output      logic    has_result,
   output      rsp_type result
);

   localparam int WIDE = (ADDR_BITS > 20) ? ADDR_BITS : 20;

   logic [ADDR_BITS-1:0] line_address_ff, line_address_in;
   logic [4:0]           row_counter_ff, row_counter_in;
   logic [11:0]          drawn_lines_ff, drawn_lines_in;
   logic [10:0]          split_at_ff, split_at_in;
   logic [3:0]           panning_shift_ff, panning_shift_in;

   logic [16:0]          start_sum;
   logic [WIDE-1:0]      frame_wide;
   logic [3:0]           shift_new;
   logic [10:0]          split_new;
   logic [ADDR_BITS-1:0] frame_addr;
   logic [ADDR_BITS-1:0] split_addr_frame, split_addr_line;
   logic [ADDR_BITS-1:0] masked_addr;
   logic [13:0]          step;
   logic [5:0]           rows, row_next;
   logic                 row_wrap;
   logic [11:0]          lines_next;
   logic                 active;
   logic                 is_text;

   assign is_text = (cfg.display_mode == DISP_TEXT);

   // frame start: scaled start address, panning shift, split line
   always_comb begin
      start_sum = {1'b0, cfg.start_addr} + 17'(cfg.pan_skip);
      case (cfg.display_mode)
         DISP_TEXT: begin
            shift_new  = 4'd2;
            frame_wide = WIDE'({start_sum, 1'b0});
         end
         DISP_VGA: begin
            shift_new  = 4'd4;
            frame_wide = WIDE'({start_sum, 2'b0});
         end
         DISP_EGA: begin
            shift_new  = 4'd8;
            frame_wide = WIDE'({start_sum, 3'b0});
         end
         default: begin
            shift_new  = 4'd0;
            frame_wide = WIDE'({cfg.start_addr[11:0], 1'b0} & CGA_MASK);
         end
      endcase
      frame_addr = frame_wide[ADDR_BITS-1:0];
      split_new  = 11'({1'b0, cfg.split_compare} + 11'd1);
      if (cfg.options[0]) begin
         split_new = split_new >> 1;
      end
   end

   assign split_addr_frame = cfg.options[1] ? '0 :
                             ADDR_BITS'(shift_new) * ADDR_BITS'(cfg.pan_skip);
   assign split_addr_line  = cfg.options[1] ? '0 :
                             ADDR_BITS'(panning_shift_ff) * ADDR_BITS'(cfg.pan_skip);

   // line tick: row advance, row step, line count
   always_comb begin
      case (cfg.display_mode)
         DISP_TEXT: step = {2'b0, cfg.row_offset, 2'b0};
         DISP_VGA:  step = {1'b0, cfg.row_offset, 3'b0};
         DISP_EGA:  step = {cfg.row_offset, 4'b0};
         default:   step = CGA_STEP;
      endcase
   end

   assign rows       = (cfg.rows_per_char > ROWS_MAX) ? ROWS_MAX : cfg.rows_per_char;
   assign row_next   = {1'b0, row_counter_ff} + 6'd1;
   // a row count of zero wraps on every line
   assign row_wrap   = (row_next >= rows);
   assign lines_next = drawn_lines_ff + 12'd1;
   assign active     = (drawn_lines_ff < {1'b0, cfg.frame_lines});
   assign has_result = (item.mode == ITEM_LINE_TICK) && active;

   assign masked_addr = line_address_ff &
                        (is_text ? ADDR_BITS'(TEXT_MASK) : {ADDR_BITS{1'b1}});
   assign result.fetch_address = 18'(masked_addr);
   assign result.char_row      = row_counter_ff;
   assign result.blank         = item.screen_blank;
   assign result.last_line     = (lines_next >= {1'b0, cfg.frame_lines});

   always_comb begin
      line_address_in  = line_address_ff;
      row_counter_in   = row_counter_ff;
      drawn_lines_in   = drawn_lines_ff;
      split_at_in      = split_at_ff;
      panning_shift_in = panning_shift_ff;
      if (item.mode == ITEM_FRAME_START) begin
         panning_shift_in = shift_new;
         split_at_in      = split_new;
         drawn_lines_in   = 12'd0;
         // split line of zero splits right away
         if (split_new == 11'd0) begin
            line_address_in = split_addr_frame;
            row_counter_in  = 5'd0;
         end else begin
            line_address_in = frame_addr;
            row_counter_in  = cfg.options[6:2];
         end
      end else if (active) begin
         drawn_lines_in = lines_next;
         if ({1'b0, split_at_ff} == lines_next) begin
            line_address_in = split_addr_line;
            row_counter_in  = 5'd0;
         end else if (row_wrap) begin
            line_address_in = line_address_ff + ADDR_BITS'(step);
            row_counter_in  = 5'd0;
         end else begin
            row_counter_in = row_next[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_address_ff  <= '0;
         row_counter_ff   <= 5'd0;
         drawn_lines_ff   <= 12'hfff;
         split_at_ff      <= 11'd0;
         panning_shift_ff <= 4'd0;
      end else if (fire) begin
         line_address_ff  <= line_address_in;
         row_counter_ff   <= row_counter_in;
         drawn_lines_ff   <= drawn_lines_in;
         split_at_ff      <= split_at_in;
         panning_shift_ff <= panning_shift_in;
      end
   end

endmodule

`default_nettype wire
